/* sv/integer_to_ascii_radix_formatter_core_defines.svh */
`ifndef INTEGER_TO_ASCII_RADIX_FORMATTER_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_FORMATTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IRF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define IRF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/irf_pkg.sv */
`timescale 1ns / 1ps

package irf_pkg;

    localparam int VALUE_W     = 48;
    localparam int PTR_BITS    = 48;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 8;
    localparam int COUNT_W     = 6;
    localparam int STACK_DEPTH = 48;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int INT_W       = 32;

    // Shared divider walks the quotient STEP_BITS bits per cycle.
    localparam int STEP_BITS  = 8;
    localparam int DIV_PHASES = VALUE_W / STEP_BITS;
    localparam int PHASE_W    = $clog2(DIV_PHASES);

    localparam logic [1:0] ACT_SIGNED   = 2'd0;
    localparam logic [1:0] ACT_UNSIGNED = 2'd1;
    localparam logic [1:0] ACT_POINTER  = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_N     = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
    localparam logic [CHAR_W-1:0] CH_L     = 8'h6C;
    localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;

    typedef struct packed {
        logic [1:0]         action;
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        logic               upper_case;
    } in_word_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  out_char;
        logic               last;
        logic [COUNT_W-1:0] total_count;
    } out_word_t;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_MINUS,
        PFX_HEX,
        PFX_NIL
    } pfx_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctl_t;

    typedef struct packed {
        logic               digit_valid;
        logic [DIGIT_W-1:0] digit;
        logic               q_zero;
    } div_stat_t;

    function automatic logic [2:0] pfx_len(input pfx_t kind);
        case (kind)
            PFX_MINUS: pfx_len = 3'd1;
            PFX_HEX:   pfx_len = 3'd2;
            PFX_NIL:   pfx_len = 3'd5;
            default:   pfx_len = 3'd0;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pfx_char(input pfx_t kind, input logic [2:0] idx);
        logic [CHAR_W-1:0] c;
        c = CH_MINUS;
        if (kind == PFX_HEX) begin
            c = (idx == 3'd0) ? CH_ZERO : CH_X;
        end
        else if (kind == PFX_NIL) begin
            case (idx)
                3'd0:    c = CH_LPAR;
                3'd1:    c = CH_N;
                3'd2:    c = CH_I;
                3'd3:    c = CH_L;
                default: c = CH_RPAR;
            endcase
        end
        pfx_char = c;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        if (d < 4'd10)
            digit_char = CH_ZERO + CHAR_W'(d);
        else if (upper)
            digit_char = CH_UA + CHAR_W'(d - 4'd10);
        else
            digit_char = CH_LA + CHAR_W'(d - 4'd10);
    endfunction

endpackage

/* sv/irf_divider.sv */
`timescale 1ns / 1ps

module irf_divider
    import irf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  div_ctl_t           ctl,
    input  logic [VALUE_W-1:0] load_value,
    input  logic [RADIX_W-1:0] load_radix,
    output div_stat_t          stat
);

    localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(DIV_PHASES - 1);

    logic [VALUE_W-1:0] quo_reg;
    logic [DIGIT_W-1:0] rem_reg;
    logic [RADIX_W-1:0] radix_reg;
    logic [PHASE_W-1:0] phase_reg;

    logic [VALUE_W-1:0]   quo_next;
    logic [DIGIT_W-1:0]   rem_next;
    logic [STEP_BITS-1:0] qbits;

    // Restoring long division on the top byte, MSB first; remainder stays below radix.
    always_comb
    begin
        logic [RADIX_W-1:0] t;
        logic [DIGIT_W-1:0] r;
        r = rem_reg;
        qbits = '0;
        for (int i = STEP_BITS - 1; i >= 0; i--)
        begin
            t = {r, quo_reg[VALUE_W - STEP_BITS + i]};
            if (t >= radix_reg)
            begin
                t = t - radix_reg;
                qbits[i] = 1'b1;
            end
            r = t[DIGIT_W-1:0];
        end
        rem_next = r;
        quo_next = {quo_reg[VALUE_W-STEP_BITS-1:0], qbits};
    end

    assign stat.digit_valid = ctl.step && (phase_reg == LAST_PHASE);
    assign stat.digit       = rem_next;
    assign stat.q_zero      = (quo_next == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (ctl.load)
        begin
            phase_reg <= '0;
        end
        else if (ctl.step)
        begin
            phase_reg <= (phase_reg == LAST_PHASE) ? '0 : phase_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            quo_reg   <= load_value;
            rem_reg   <= '0;
            radix_reg <= load_radix;
        end
        else if (ctl.step)
        begin
            quo_reg <= quo_next;
            rem_reg <= (phase_reg == LAST_PHASE) ? '0 : rem_next;
        end
    end

endmodule

/* sv/irf_digit_stack.sv */
`timescale 1ns / 1ps

module irf_digit_stack
    import irf_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [DIGIT_W-1:0] wr_digit,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [DIGIT_W-1:0] rd_digit
);

    logic [DIGIT_W-1:0] mem [STACK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_digit;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_digit <= mem[rd_addr];
    end

endmodule

/* sv/integer_to_ascii_radix_formatter_core.sv */
// Formats one number per request word and streams its ASCII characters, most
// significant first, one character per output word; the final word carries
// last and the character count. The block takes a request only when idle. A
// shared radix divider produces one digit per pass over the full quotient (it
// walks the 48-bit quotient 8 bits per cycle) and pushes digits onto a
// 48-entry stack memory; a load state then settles the stack read, and
// characters go out one per cycle while the output side takes them. An unused
// action code is consumed with no output.
`timescale 1ns / 1ps

`include "integer_to_ascii_radix_formatter_core_defines.svh"

module integer_to_ascii_radix_formatter_core
    import irf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DIV    = 5'b00010,
        S_LOAD   = 5'b00100,
        S_PREFIX = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t              state_reg,  state_next;
    pfx_t                kind_reg,   kind_next;
    logic                upper_reg,  upper_next;
    logic [2:0]          pidx_reg,   pidx_next;
    logic [ADDR_W-1:0]   dcount_reg, dcount_next;
    logic [COUNT_W-1:0]  ecount_reg, ecount_next;
    logic                out_valid_reg;
    out_word_t           out_data_reg;

    div_ctl_t            div_ctl;
    div_stat_t           div_stat;
    logic [VALUE_W-1:0]  mag;
    logic [INT_W-1:0]    neg_lo;
    logic [RADIX_W-1:0]  radix_sat;
    logic                can_push;
    logic                push;
    out_word_t           push_word;
    logic                wr_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [DIGIT_W-1:0]  rd_digit;
    logic                accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign can_push  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Negate in 32 bits so the most negative value maps to 2^31.
    assign neg_lo = INT_W'(0) - in_data.value[INT_W-1:0];

    always_comb
    begin
        if (in_data.radix < RADIX_MIN)
            radix_sat = RADIX_MIN;
        else if (in_data.radix > RADIX_MAX)
            radix_sat = RADIX_MAX;
        else
            radix_sat = in_data.radix;
    end

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        upper_next  = upper_reg;
        pidx_next   = pidx_reg;
        dcount_next = dcount_reg;
        ecount_next = ecount_reg;
        div_ctl     = '0;
        mag         = '0;
        wr_en       = 1'b0;
        push        = 1'b0;
        push_word   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    upper_next  = in_data.upper_case;
                    pidx_next   = '0;
                    dcount_next = '0;
                    ecount_next = '0;
                    case (in_data.action)
                        ACT_SIGNED:
                        begin
                            // Two's complement negate; the most negative value maps to 2^31.
                            if (in_data.value[INT_W-1])
                            begin
                                mag       = VALUE_W'(neg_lo);
                                kind_next = PFX_MINUS;
                            end
                            else
                            begin
                                mag       = VALUE_W'(in_data.value[INT_W-1:0]);
                                kind_next = PFX_NONE;
                            end
                            div_ctl.load = 1'b1;
                            state_next   = S_DIV;
                        end
                        ACT_UNSIGNED:
                        begin
                            mag          = VALUE_W'(in_data.value[INT_W-1:0]);
                            kind_next    = PFX_NONE;
                            div_ctl.load = 1'b1;
                            state_next   = S_DIV;
                        end
                        ACT_POINTER:
                        begin
                            mag = VALUE_W'(in_data.value[PTR_BITS-1:0]);
                            if (mag == '0)
                            begin
                                kind_next  = PFX_NIL;
                                state_next = S_PREFIX;
                            end
                            else
                            begin
                                kind_next    = PFX_HEX;
                                div_ctl.load = 1'b1;
                                state_next   = S_DIV;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_DIV:
            begin
                div_ctl.step = 1'b1;
                if (div_stat.digit_valid)
                begin
                    wr_en       = 1'b1;
                    dcount_next = dcount_reg + 1'b1;
                    if (div_stat.q_zero)
                        state_next = S_LOAD;
                end
            end

            S_LOAD:
            begin
                // Wait here for the top-of-stack read to land.
                state_next = (pfx_len(kind_reg) != 3'd0) ? S_PREFIX : S_EMIT;
            end

            S_PREFIX:
            begin
                if (can_push)
                begin
                    push               = 1'b1;
                    push_word.out_char = pfx_char(kind_reg, pidx_reg);
                    pidx_next          = pidx_reg + 1'b1;
                    if (pidx_reg == pfx_len(kind_reg) - 3'd1)
                    begin
                        push_word.last = (kind_reg == PFX_NIL);
                        state_next     = (kind_reg == PFX_NIL) ? S_IDLE : S_EMIT;
                    end
                end
            end

            S_EMIT:
            begin
                if (can_push)
                begin
                    push               = 1'b1;
                    push_word.out_char = digit_char(rd_digit, upper_reg);
                    push_word.last     = (dcount_reg == ADDR_W'(1));
                    dcount_next        = dcount_reg - 1'b1;
                    if (dcount_reg == ADDR_W'(1))
                        state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push)
        begin
            ecount_next = ecount_reg + 1'b1;
            if (push_word.last)
                push_word.total_count = ecount_reg + 1'b1;
        end
    end

    // Read ahead at the next top of stack so the digit is ready after a pop.
    assign rd_addr = (dcount_next == '0) ? '0 : dcount_next - 1'b1;

    irf_divider u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (div_ctl),
        .load_value (mag),
        .load_radix (radix_sat),
        .stat       (div_stat)
    );

    irf_digit_stack u_stack (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (dcount_reg),
        .wr_digit (div_stat.digit),
        .rd_addr  (rd_addr),
        .rd_digit (rd_digit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= PFX_NONE;
            upper_reg     <= 1'b0;
            pidx_reg      <= '0;
            dcount_reg    <= '0;
            ecount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            upper_reg  <= upper_next;
            pidx_reg   <= pidx_next;
            dcount_reg <= dcount_next;
            ecount_reg <= ecount_next;
            if (push)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_data_reg <= push_word;
        end
    end

    `IRF_ASSERT_IMP(a_idle_stack_empty, state_reg == S_IDLE, dcount_reg == '0,
                    "stack not empty when idle")
    `IRF_ASSERT_IMP(a_push_in_range, div_stat.digit_valid,
                    dcount_reg < ADDR_W'(STACK_DEPTH), "digit stack overflow")
    `IRF_ASSERT_IMP(a_emit_has_digit, state_reg == S_EMIT, dcount_reg != '0,
                    "emit with empty stack")
    `IRF_ASSERT_NXT(a_push_shows, push,
                    out_valid && out_data.out_char == $past(push_word.out_char),
                    "pushed char lost")

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import irf_pkg::*;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         DRAIN_CYCLES = 500;
    localparam int         RANDOM_COUNT = 190;
    localparam int         STEADY_COUNT = 30;
    localparam int         PRINT_CAP    = 30;

    typedef struct {
        out_word_t word;
        int        req;
    } char_expect_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_word_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_data;

    char_expect_t expected_chars[$];
    char_expect_t want;
    int           error_count   = 0;
    int           requests_sent = 0;
    int           requests_ignored = 0;
    int           chars_checked = 0;
    int           cycle_count   = 0;
    int           stall_left    = 0;
    bit           steady        = 1'b0;

    integer_to_ascii_radix_formatter_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d characters still due",
                 cycle_count, expected_chars.size());
        $display("integer_to_ascii_radix_formatter_core: mismatch");
        $finish;
    end

    task automatic note_mismatch(input string field, input int req,
                                 input logic [7:0] expected, input logic [7:0] actual);
        begin
            error_count++;
            if (error_count <= PRINT_CAP)
                $display("request %0d: %s expected %0h, got %0h", req, field, expected, actual);
        end
    endtask

    // Expected characters of one request, in output order.
    function automatic void format_request(input in_word_t req, input int id);
        logic [4:0]  base;
        logic [47:0] mag;
        logic [31:0] lo;
        logic [3:0]  digit;
        logic [7:0]  text[$];
        char_expect_t item;
        begin
            base = req.radix;
            if (base < 5'd2)
                base = 5'd2;
            if (base > 5'd16)
                base = 5'd16;
            if (req.action == ACT_UNUSED)
                return;
            mag = '0;
            if (req.action == ACT_SIGNED) begin
                lo = req.value[31:0];
                if (lo[31])
                begin
                    // Negating in 32 bits leaves the most negative value as its own magnitude.
                    lo = -lo;
                    text.push_back(CH_MINUS);
                end
                mag = {16'h0, lo};
            end
            else if (req.action == ACT_UNSIGNED)
            begin
                mag = {16'h0, req.value[31:0]};
            end
            else
            begin
                mag = req.value;
                if (mag == '0)
                begin
                    text.push_back(CH_LPAR);
                    text.push_back(CH_N);
                    text.push_back(CH_I);
                    text.push_back(CH_L);
                    text.push_back(CH_RPAR);
                end
                else
                begin
                    text.push_back(CH_ZERO);
                    text.push_back(CH_X);
                end
            end
            if (!(req.action == ACT_POINTER && mag == '0))
            begin
                begin : digits
                    logic [7:0] rev[$];
                    do
                    begin
                        digit = 4'(mag % base);
                        mag   = mag / base;
                        if (digit < 4'd10)
                            rev.push_front(CH_ZERO + 8'(digit));
                        else if (req.upper_case)
                            rev.push_front(CH_UA + 8'(digit - 4'd10));
                        else
                            rev.push_front(CH_LA + 8'(digit - 4'd10));
                    end
                    while (mag != '0);
                    foreach (rev[k])
                        text.push_back(rev[k]);
                end
            end
            foreach (text[k])
            begin
                item.req                   = id;
                item.word.out_char         = text[k];
                item.word.last             = (k == text.size() - 1);
                item.word.total_count      = item.word.last ? 6'(text.size()) : 6'd0;
                expected_chars.push_back(item);
            end
        end
    endfunction

    function automatic in_word_t make_request(input logic [1:0] action, input logic [47:0] value,
                                              input logic [4:0] radix, input logic upper);
        in_word_t req;
        begin
            req.action     = action;
            req.value      = value;
            req.radix      = radix;
            req.upper_case = upper;
            return req;
        end
    endfunction

    function automatic logic [47:0] pick_value();
        logic [47:0] v;
        begin
            case ($urandom_range(0, 5))
                0:       v = {16'($urandom), 32'($urandom)};
                1:       v = 48'($urandom_range(0, 20));
                2:       v = {16'h0, 32'($urandom)};
                3:       v = {16'($urandom), 32'h8000_0000 + 32'($urandom_range(0, 3))};
                4:       v = 48'h1 << $urandom_range(0, 47);
                default: v = {16'($urandom), 32'hFFFF_FFFF} - 48'($urandom_range(0, 3));
            endcase
            return v;
        end
    endfunction

    function automatic in_word_t random_request();
        logic [1:0] action;
        logic [4:0] radix;
        int         pick;
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                action = ACT_SIGNED;
            else if (pick < 6)
                action = ACT_UNSIGNED;
            else if (pick < 9)
                action = ACT_POINTER;
            else
                action = ACT_UNUSED;
            // Mostly legal bases; now and then one that saturates.
            if ($urandom_range(0, 9) == 0)
                radix = 5'($urandom_range(0, 31));
            else
                radix = 5'($urandom_range(2, 16));
            return make_request(action, pick_value(), radix, 1'($urandom_range(0, 1)));
        end
    endfunction

    // Leave valid high after the handshake; the next call lowers it only for a gap.
    task automatic send_request(input in_word_t req);
        int gap;
        begin
            if (!steady && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 10);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= req;
            do
                @(posedge clk);
            while (!in_ready);
            format_request(req, requests_sent);
            requests_sent++;
            if (req.action == ACT_UNUSED)
                requests_ignored++;
        end
    endtask

    // Hold ready low in random bursts; keep it high during the steady test.
    always @(posedge clk)
    begin
        if (!rst_n || steady)
        begin
            out_ready <= rst_n;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 9);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            chars_checked++;
            if (expected_chars.size() == 0)
            begin
                note_mismatch("unexpected word, char", -1, 8'h0, out_data.out_char);
            end
            else
            begin
                want = expected_chars.pop_front();
                if (out_data.out_char !== want.word.out_char)
                    note_mismatch("out_char", want.req, want.word.out_char, out_data.out_char);
                if (out_data.last !== want.word.last)
                    note_mismatch("last", want.req, 8'(want.word.last), 8'(out_data.last));
                if (out_data.total_count !== want.word.total_count)
                    note_mismatch("total_count", want.req, 8'(want.word.total_count),
                                  8'(out_data.total_count));
            end
        end
    end

    task automatic test_directed();
        begin
            send_request(make_request(ACT_SIGNED,   48'h0,              5'd10, 1'b0));
            send_request(make_request(ACT_SIGNED,   48'h1,              5'd10, 1'b0));
            send_request(make_request(ACT_SIGNED,   48'hFFFF_FFFF,      5'd10, 1'b0));
            send_request(make_request(ACT_SIGNED,   48'h7FFF_FFFF,      5'd10, 1'b0));
            send_request(make_request(ACT_SIGNED,   48'h8000_0000,      5'd10, 1'b0));
            send_request(make_request(ACT_SIGNED,   48'h8000_0000,      5'd2,  1'b1));
            // Upper bits do not belong to an integer.
            send_request(make_request(ACT_SIGNED,   48'hFFFF_0000_0000, 5'd16, 1'b0));
            send_request(make_request(ACT_SIGNED,   48'hABCD_1234_5678, 5'd16, 1'b1));
            send_request(make_request(ACT_UNSIGNED, 48'h0,              5'd2,  1'b0));
            send_request(make_request(ACT_UNSIGNED, 48'hFFFF_FFFF,      5'd2,  1'b0));
            send_request(make_request(ACT_UNSIGNED, 48'hFFFF_FFFF,      5'd16, 1'b0));
            send_request(make_request(ACT_UNSIGNED, 48'hFFFF_FFFF,      5'd16, 1'b1));
            send_request(make_request(ACT_UNSIGNED, 48'hFFFF_0000_00FF, 5'd8,  1'b0));
            send_request(make_request(ACT_POINTER,  48'h0,              5'd16, 1'b0));
            send_request(make_request(ACT_POINTER,  48'h0,              5'd0,  1'b1));
            send_request(make_request(ACT_POINTER,  48'hFFFF_FFFF_FFFF, 5'd2,  1'b0));
            send_request(make_request(ACT_POINTER,  48'h0001_0000_0000, 5'd16, 1'b0));
            send_request(make_request(ACT_POINTER,  48'hDEAD_BEEF_CAFE, 5'd16, 1'b1));
            send_request(make_request(ACT_POINTER,  48'h1,              5'd16, 1'b0));
            send_request(make_request(ACT_UNUSED,   48'hFFFF_FFFF_FFFF, 5'd2,  1'b1));
            send_request(make_request(ACT_UNUSED,   48'h0,              5'd0,  1'b0));
            send_request(make_request(ACT_UNSIGNED, 48'd12345,          5'd0,  1'b0));
            send_request(make_request(ACT_SIGNED,   -48'sd12345,        5'd1,  1'b0));
            send_request(make_request(ACT_UNSIGNED, 48'hAB_CDEF,        5'd17, 1'b0));
            send_request(make_request(ACT_POINTER,  48'h1234,           5'd31, 1'b1));
        end
    endtask

    task automatic test_radix_sweep();
        begin
            for (int r = 0; r < 32; r++)
                send_request(make_request(2'($urandom_range(0, 2)), pick_value(), 5'(r),
                                          1'($urandom_range(0, 1))));
        end
    endtask

    task automatic test_random_requests();
        begin
            repeat (RANDOM_COUNT)
                send_request(random_request());
        end
    endtask

    task automatic test_back_to_back();
        begin
            steady = 1'b1;
            repeat (STEADY_COUNT)
                send_request(random_request());
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_radix_sweep();
        test_random_requests();
        test_back_to_back();
        in_valid <= 1'b0;

        while (expected_chars.size() != 0)
            @(posedge clk);
        // Catch any word the block sends beyond what was due.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests (%0d with an unused action), %0d characters checked",
                 requests_sent, requests_ignored, chars_checked);
        $display("signed, unsigned and pointer modes, bases 0 to 31, stalls on both sides");
        if (error_count == 0 && expected_chars.size() == 0)
            $display("integer_to_ascii_radix_formatter_core: match");
        else
            $display("integer_to_ascii_radix_formatter_core: mismatch");
        $finish;
    end

endmodule
